/* rtl/btpt_pkg.sv */
package btpt_pkg;

  localparam int NODES    = 1024;
  localparam int NODE_AW  = $clog2(NODES);
  localparam int FC_W     = NODE_AW + 1;
  localparam int KEY_BITS = 16;
  localparam int HOP_BITS = 16;
  localparam int LEN_W    = 5;
  localparam int DEPTH_W  = 5;
  localparam int KIDX_W   = 4;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_DELETE = 2'd1;
  localparam logic [1:0] KIND_LOOKUP = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic [HOP_BITS-1:0] hop;
    logic                valid;
    logic [NODE_AW-1:0]  left;
    logic [NODE_AW-1:0]  right;
  } node_t;

  typedef struct packed {
    logic clr;
    logic load;
    logic rd_cur;
    logic chk;
    logic adv;
    logic set_full;
    logic set_nf;
    logic rd_fs;
    logic link;
    logic set_hop;
    logic del_clr;
    logic rd_par;
    logic prune;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic       clr_last;
    logic       walk_end;
    logic       child_zero;
    logic       full;
    logic       prune_ok;
    logic       out_busy;
    logic [1:0] kind;
  } dp_stat_t;

endpackage

/* rtl/btpt_ctrl.sv */
module btpt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  btpt_pkg::dp_stat_t stat,
  output btpt_pkg::dp_cmd_t  cmd
);

  typedef enum logic [12:0] {
    S_CLR   = 13'b0000000000001,
    S_IDLE  = 13'b0000000000010,
    S_RD    = 13'b0000000000100,
    S_CHK   = 13'b0000000001000,
    S_POP   = 13'b0000000010000,
    S_LINK  = 13'b0000000100000,
    S_SETH  = 13'b0000001000000,
    S_DCLR  = 13'b0000010000000,
    S_PCHK  = 13'b0000100000000,
    S_PRD   = 13'b0001000000000,
    S_PWR   = 13'b0010000000000,
    S_DONE  = 13'b0100000000000,
    S_SPARE = 13'b1000000000000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLR: begin
        cmd.clr = 1'b1;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_RD;
        end
      end
      S_RD: begin
        cmd.rd_cur = 1'b1;
        state_next = S_CHK;
      end
      S_CHK: begin
        cmd.chk = 1'b1;
        case (stat.kind)
          btpt_pkg::KIND_LOOKUP: begin
            if (stat.walk_end || stat.child_zero) begin
              state_next = S_DONE;
            end else begin
              cmd.adv    = 1'b1;
              state_next = S_RD;
            end
          end
          btpt_pkg::KIND_INSERT: begin
            if (!stat.walk_end && !stat.child_zero) begin
              cmd.adv    = 1'b1;
              state_next = S_RD;
            end else if (stat.full) begin
              cmd.set_full = 1'b1;
              state_next   = S_DONE;
            end else if (stat.walk_end) begin
              state_next = S_SETH;
            end else begin
              state_next = S_POP;
            end
          end
          btpt_pkg::KIND_DELETE: begin
            if (stat.walk_end) begin
              state_next = S_DCLR;
            end else if (stat.child_zero) begin
              cmd.set_nf = 1'b1;
              state_next = S_DONE;
            end else begin
              cmd.adv    = 1'b1;
              state_next = S_RD;
            end
          end
          default: state_next = S_DONE;
        endcase
      end
      S_POP: begin
        if (stat.walk_end) begin
          state_next = S_SETH;
        end else begin
          cmd.rd_fs  = 1'b1;
          state_next = S_LINK;
        end
      end
      S_LINK: begin
        cmd.link   = 1'b1;
        state_next = S_POP;
      end
      S_SETH: begin
        cmd.set_hop = 1'b1;
        state_next  = S_DONE;
      end
      S_DCLR: begin
        cmd.del_clr = 1'b1;
        state_next  = S_PCHK;
      end
      S_PCHK: begin
        state_next = stat.prune_ok ? S_PRD : S_DONE;
      end
      S_PRD: begin
        cmd.rd_par = 1'b1;
        state_next = S_PWR;
      end
      S_PWR: begin
        cmd.prune  = 1'b1;
        state_next = S_PCHK;
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

/* rtl/btpt_dp.sv */
module btpt_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  btpt_pkg::dp_cmd_t                 cmd,
  output btpt_pkg::dp_stat_t                stat,
  input  logic [1:0]                        in_kind,
  input  logic [btpt_pkg::KEY_BITS-1:0]     in_key,
  input  logic [btpt_pkg::LEN_W-1:0]        in_len,
  input  logic [btpt_pkg::HOP_BITS-1:0]     in_hop,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_status,
  output logic                              out_found,
  output logic [btpt_pkg::HOP_BITS-1:0]     out_hop
);

  btpt_pkg::node_t node_mem [btpt_pkg::NODES];
  logic [btpt_pkg::NODE_AW-1:0] fs_mem [btpt_pkg::NODES];

  btpt_pkg::node_t node_q, nq, par_new, wdata;
  logic [btpt_pkg::NODE_AW-1:0] fs_q;
  logic [btpt_pkg::NODE_AW-1:0] path [btpt_pkg::KEY_BITS];

  logic [1:0]                       kind;
  logic [btpt_pkg::KEY_BITS-1:0]    key;
  logic [btpt_pkg::LEN_W-1:0]       len;
  logic [btpt_pkg::HOP_BITS-1:0]    hop;
  logic [btpt_pkg::NODE_AW-1:0]     n;
  logic [btpt_pkg::DEPTH_W-1:0]     d;
  logic                             found;
  logic [btpt_pkg::HOP_BITS-1:0]    res;
  logic [1:0]                       status;
  logic [btpt_pkg::FC_W-1:0]        fc;
  logic [btpt_pkg::NODE_AW-1:0]     clr_cnt;

  logic [btpt_pkg::KIDX_W-1:0]  kidx, pidx, dm1;
  logic                         cbit, pbit;
  logic [btpt_pkg::NODE_AW-1:0] child, rd_addr, waddr, parent;
  logic [btpt_pkg::DEPTH_W-1:0] lim;
  logic                         we;

  assign dm1    = btpt_pkg::KIDX_W'(d - 1'b1);
  assign kidx   = btpt_pkg::KIDX_W'(btpt_pkg::KEY_BITS - 1) - d[btpt_pkg::KIDX_W-1:0];
  assign pidx   = btpt_pkg::KIDX_W'(btpt_pkg::KEY_BITS - 1) - dm1;
  assign cbit   = key[kidx];
  assign pbit   = key[pidx];
  assign child  = cbit ? node_q.right : node_q.left;
  assign parent = path[dm1];
  assign lim    = (kind == btpt_pkg::KIND_LOOKUP) ?
                  btpt_pkg::DEPTH_W'(btpt_pkg::KEY_BITS) : btpt_pkg::DEPTH_W'(len);

  always_comb begin
    par_new = node_q;
    if (pbit) par_new.right = '0;
    else      par_new.left  = '0;
  end

  assign stat.clr_last   = (clr_cnt == btpt_pkg::NODE_AW'(btpt_pkg::NODES - 1));
  assign stat.walk_end   = (d == lim);
  assign stat.child_zero = (child == '0);
  assign stat.full       = btpt_pkg::FC_W'(btpt_pkg::DEPTH_W'(len) - d) > fc;
  assign stat.prune_ok   = (d != '0) && !nq.valid && (nq.left == '0) && (nq.right == '0);
  assign stat.out_busy   = out_valid && !out_ready;
  assign stat.kind       = kind;

  assign rd_addr = cmd.rd_par ? parent : n;

  always_comb begin
    we    = 1'b1;
    waddr = n;
    wdata = nq;
    if (cmd.clr) begin
      waddr = clr_cnt;
      wdata = '0;
    end else if (cmd.link) begin
      if (cbit) wdata.right = fs_q;
      else      wdata.left  = fs_q;
    end else if (cmd.set_hop) begin
      wdata.hop   = hop;
      wdata.valid = 1'b1;
    end else if (cmd.del_clr) begin
      wdata.hop   = '0;
      wdata.valid = 1'b0;
    end else if (cmd.prune) begin
      waddr = parent;
      wdata = par_new;
    end else begin
      we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) node_mem[waddr] <= wdata;
    if (cmd.rd_cur || cmd.rd_par) node_q <= node_mem[rd_addr];
    if (cmd.clr) begin
      fs_mem[clr_cnt] <= btpt_pkg::NODE_AW'(clr_cnt + 1'b1);
    end else if (cmd.prune) begin
      fs_mem[fc[btpt_pkg::NODE_AW-1:0]] <= n;
    end
    if (cmd.rd_fs) fs_q <= fs_mem[btpt_pkg::NODE_AW'(fc - 1'b1)];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind   <= in_kind;
      key    <= in_key;
      len    <= (in_len > btpt_pkg::LEN_W'(btpt_pkg::KEY_BITS)) ?
                btpt_pkg::LEN_W'(btpt_pkg::KEY_BITS) : in_len;
      hop    <= in_hop;
      n      <= '0;
      d      <= '0;
      found  <= 1'b0;
      res    <= '0;
      status <= btpt_pkg::ST_OK;
    end
    if (cmd.chk) begin
      nq <= node_q;
      if (kind == btpt_pkg::KIND_LOOKUP && node_q.valid) begin
        found <= 1'b1;
        res   <= node_q.hop;
      end
      if (kind == btpt_pkg::KIND_DELETE && !stat.walk_end) begin
        path[d[btpt_pkg::KIDX_W-1:0]] <= n;
      end
    end
    if (cmd.adv) begin
      n <= child;
      d <= d + 1'b1;
    end
    if (cmd.set_full) status <= btpt_pkg::ST_FULL;
    if (cmd.set_nf)   status <= btpt_pkg::ST_NOT_FOUND;
    if (cmd.link) begin
      n  <= fs_q;
      nq <= '0;
      d  <= d + 1'b1;
    end
    if (cmd.del_clr) begin
      nq.hop   <= '0;
      nq.valid <= 1'b0;
    end
    if (cmd.prune) begin
      n  <= parent;
      nq <= par_new;
      d  <= d - 1'b1;
    end
    if (cmd.emit) begin
      out_status <= status;
      out_found  <= found;
      out_hop    <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fc        <= btpt_pkg::FC_W'(btpt_pkg::NODES - 1);
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clr) clr_cnt <= clr_cnt + 1'b1;
      if (cmd.link)       fc <= fc - 1'b1;
      else if (cmd.prune) fc <= fc + 1'b1;
      if (cmd.emit)           out_valid <= 1'b1;
      else if (out_ready)     out_valid <= 1'b0;
    end
  end

endmodule

/* rtl/binary_trie_prefix_table_unit.sv */
// Channel  Dir  Signals                         Contents
// s        in   s_tvalid s_tready s_tdata s_tuser  insert/delete/lookup request
// m        out  m_tvalid m_tready m_tdata          status, hop_found, result_hop
//
// One item at a time. Lookup reads each node on the key path; insert
// walks existing levels, links a new node per missing level; delete
// walks down, then prunes emptied nodes. Node memory port sets the pace.
// After reset a clearing pass over all 1024 nodes runs before s_tready rises.
// A held result in m does not block acceptance; the next finish waits on it.
module binary_trie_prefix_table_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // key[15:0], prefix_len[20:16], next_hop[36:21]
  input  logic [1:0]  s_tuser,  // kind[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata   // status[1:0], hop_found[2], result_hop[18:3]
);

  btpt_pkg::dp_cmd_t  cmd;
  btpt_pkg::dp_stat_t stat;
  logic [1:0]                    out_status;
  logic                          out_found;
  logic [btpt_pkg::HOP_BITS-1:0] out_hop;

  btpt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  btpt_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_kind    (s_tuser),
    .in_key     (s_tdata[15:0]),
    .in_len     (s_tdata[20:16]),
    .in_hop     (s_tdata[36:21]),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (out_status),
    .out_found  (out_found),
    .out_hop    (out_hop)
  );

  assign m_tdata = {5'd0, out_hop, out_found, out_status};

endmodule

/* rtl/btpt_checker.sv */
module btpt_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  a_clear_after_reset: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("input taken during clearing pass");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[1:0] != 2'd3)
    else $error("bad status code");

  a_err_no_hop: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] != btpt_pkg::ST_OK |-> m_tdata[18:2] == 17'd0)
    else $error("error result carries a hop");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[2] |-> m_tdata[18:3] == 16'd0)
    else $error("miss carries a hop");

endmodule

bind binary_trie_prefix_table_unit btpt_checker u_btpt_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

/* tb/sv/testbench.sv */
module testbench;

  localparam int IDLE_LIMIT = 20000;
  localparam logic [1:0] KIND_NONE = 2'd3;

  typedef struct {
    logic [1:0]  kind;
    logic [15:0] key;
    logic [4:0]  plen;
    logic [15:0] hop;
    bit          typed;
    logic [1:0]  st;
    logic        f;
    logic [15:0] rh;
  } req_row_t;

  typedef struct {
    logic [1:0]  st;
    logic        f;
    logic [15:0] rh;
  } route_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;

  binary_trie_prefix_table_unit i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // trie shadow
  logic [15:0] t_hop [btpt_pkg::NODES];
  logic        t_valid [btpt_pkg::NODES];
  logic [9:0]  t_left [btpt_pkg::NODES];
  logic [9:0]  t_right [btpt_pkg::NODES];
  logic [9:0]  t_free [btpt_pkg::NODES];
  int          t_free_cnt;
  logic [9:0]  t_path [btpt_pkg::KEY_BITS];

  route_t      pending_routes [$];
  int          errors = 0;
  int          cycle = 0;
  int          quiet = 0;
  logic [15:0] pfx_key [40];
  logic [4:0]  pfx_len [40];

  function automatic logic [9:0] kid(int n, logic b);
    return b ? t_right[n] : t_left[n];
  endfunction

  function automatic void set_kid(int n, logic b, logic [9:0] c);
    if (b) t_right[n] = c;
    else t_left[n] = c;
  endfunction

  function automatic void clear_node(int n);
    t_hop[n] = '0; t_valid[n] = 1'b0; t_left[n] = '0; t_right[n] = '0;
  endfunction

  function automatic void trie_reset();
    for (int i = 0; i < btpt_pkg::NODES; i++) begin
      clear_node(i);
      t_free[i] = (i + 1 < btpt_pkg::NODES) ? 10'(i + 1) : '0;
    end
    t_free_cnt = btpt_pkg::NODES - 1;
  endfunction

  function automatic route_t route_step(logic [1:0] kind, logic [15:0] key,
                                        logic [4:0] plen, logic [15:0] hop);
    route_t r;
    int len, d, n, c, par;
    r = '{st: btpt_pkg::ST_OK, f: 1'b0, rh: '0};
    len = (plen > btpt_pkg::KEY_BITS) ? btpt_pkg::KEY_BITS : plen;
    n = 0;
    if (kind == btpt_pkg::KIND_INSERT) begin
      d = 0;
      while (d < len) begin
        c = kid(n, key[15-d]);
        if (c == 0) break;
        n = c;
        d++;
      end
      if (len - d > t_free_cnt) begin
        r.st = btpt_pkg::ST_FULL;
      end else begin
        while (d < len) begin
          t_free_cnt--;
          c = t_free[t_free_cnt];
          clear_node(c);
          set_kid(n, key[15-d], 10'(c));
          n = c;
          d++;
        end
        t_hop[n] = hop;
        t_valid[n] = 1'b1;
      end
    end else if (kind == btpt_pkg::KIND_DELETE) begin
      for (d = 0; d < len; d++) begin
        t_path[d] = 10'(n);
        c = kid(n, key[15-d]);
        if (c == 0) begin
          r.st = btpt_pkg::ST_NOT_FOUND;
          break;
        end
        n = c;
      end
      if (r.st == btpt_pkg::ST_OK) begin
        t_valid[n] = 1'b0;
        t_hop[n] = '0;
        d = len;
        while (d > 0 && !t_valid[n] && t_left[n] == 0 && t_right[n] == 0) begin
          par = t_path[d-1];
          set_kid(par, key[16-d], '0);
          clear_node(n);
          if (t_free_cnt < btpt_pkg::NODES) begin
            t_free[t_free_cnt] = 10'(n);
            t_free_cnt++;
          end
          n = par;
          d--;
        end
      end
    end else if (kind == btpt_pkg::KIND_LOOKUP) begin
      if (t_valid[0]) begin
        r.f = 1'b1; r.rh = t_hop[0];
      end
      for (d = 0; d < btpt_pkg::KEY_BITS; d++) begin
        c = kid(n, key[15-d]);
        if (c == 0) break;
        n = c;
        if (t_valid[n]) begin
          r.f = 1'b1; r.rh = t_hop[n];
        end
      end
    end
    return r;
  endfunction

  function automatic bit calm();
    return cycle >= 20000 && cycle < 32000;
  endfunction

  function automatic bit want_idle();
    return !calm() && $urandom_range(99) < 23;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycle);
    errors++;
  endtask

  task automatic send_req(req_row_t r);
    route_t p;
    s_tdata <= {3'b0, r.hop, r.plen, r.key};
    s_tuser <= r.kind;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    p = route_step(r.kind, r.key, r.plen, r.hop);
    if (r.typed) p = '{st: r.st, f: r.f, rh: r.rh};
    pending_routes.push_back(p);
    if (want_idle()) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_routes.size() != 0) @(posedge clk);
  endtask

  function automatic req_row_t row(logic [1:0] k, logic [15:0] key, logic [4:0] l,
                                   logic [15:0] h);
    return '{kind: k, key: key, plen: l, hop: h, typed: 1'b0, st: '0, f: '0, rh: '0};
  endfunction

  function automatic req_row_t trow(logic [1:0] k, logic [15:0] key, logic [4:0] l,
                                    logic [15:0] h, logic [1:0] st, logic f,
                                    logic [15:0] rh);
    return '{kind: k, key: key, plen: l, hop: h, typed: 1'b1, st: st, f: f, rh: rh};
  endfunction

  always @(posedge clk) begin
    route_t w;
    cycle <= cycle + 1;
    if (m_tvalid && m_tready) begin
      if (pending_routes.size() == 0) begin
        report("unexpected transfer", 32'(m_tdata), 0);
      end else begin
        w = pending_routes.pop_front();
        if (m_tdata[1:0] != w.st) report("status", 32'(m_tdata[1:0]), 32'(w.st));
        if (m_tdata[2] != w.f) report("hop_found", 32'(m_tdata[2]), 32'(w.f));
        if (m_tdata[18:3] != w.rh) report("result_hop", 32'(m_tdata[18:3]), 32'(w.rh));
      end
    end
    m_tready <= !want_idle();
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else if (quiet >= IDLE_LIMIT) begin
      $display("** binary_trie_prefix_table_unit: FAILED **");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    req_row_t dir [$];
    req_row_t r;
    int sel, kc;
    trie_reset();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    dir.push_back(trow(btpt_pkg::KIND_LOOKUP, 16'h0000, 5'd0, 16'h0000,
                       btpt_pkg::ST_OK, 1'b0, 16'h0));
    dir.push_back(trow(btpt_pkg::KIND_DELETE, 16'h8000, 5'd3, 16'h0000,
                       btpt_pkg::ST_NOT_FOUND, 1'b0, 16'h0));
    dir.push_back(trow(KIND_NONE, 16'h1234, 5'd4, 16'h4321, btpt_pkg::ST_OK, 1'b0, 16'h0));
    dir.push_back(trow(btpt_pkg::KIND_DELETE, 16'h0000, 5'd0, 16'h0000,
                       btpt_pkg::ST_OK, 1'b0, 16'h0));
    dir.push_back(trow(btpt_pkg::KIND_INSERT, 16'h0000, 5'd0, 16'hFFFF,
                       btpt_pkg::ST_OK, 1'b0, 16'h0));
    dir.push_back(trow(btpt_pkg::KIND_LOOKUP, 16'hFFFF, 5'd0, 16'h0000,
                       btpt_pkg::ST_OK, 1'b1, 16'hFFFF));
    dir.push_back(trow(btpt_pkg::KIND_INSERT, 16'hFFFF, 5'd16, 16'h1234,
                       btpt_pkg::ST_OK, 1'b0, 16'h0));
    dir.push_back(trow(btpt_pkg::KIND_LOOKUP, 16'hFFFF, 5'd0, 16'h0000,
                       btpt_pkg::ST_OK, 1'b1, 16'h1234));
    dir.push_back(trow(btpt_pkg::KIND_INSERT, 16'h0000, 5'd31, 16'h0001,
                       btpt_pkg::ST_OK, 1'b0, 16'h0));
    dir.push_back(trow(btpt_pkg::KIND_LOOKUP, 16'h0000, 5'd0, 16'h0000,
                       btpt_pkg::ST_OK, 1'b1, 16'h0001));
    dir.push_back(trow(btpt_pkg::KIND_INSERT, 16'h8000, 5'd1, 16'hAAAA,
                       btpt_pkg::ST_OK, 1'b0, 16'h0));
    dir.push_back(row(btpt_pkg::KIND_LOOKUP, 16'h8001, 5'd7, 16'h0000));
    dir.push_back(trow(btpt_pkg::KIND_DELETE, 16'hFFFF, 5'd16, 16'h0000,
                       btpt_pkg::ST_OK, 1'b0, 16'h0));
    dir.push_back(row(btpt_pkg::KIND_LOOKUP, 16'hFFFF, 5'd16, 16'h0000));
    dir.push_back(trow(btpt_pkg::KIND_DELETE, 16'hFFFF, 5'd16, 16'h0000,
                       btpt_pkg::ST_NOT_FOUND, 1'b0, 16'h0));
    dir.push_back(trow(btpt_pkg::KIND_DELETE, 16'h0000, 5'd20, 16'h0000,
                       btpt_pkg::ST_OK, 1'b0, 16'h0));
    dir.push_back(trow(btpt_pkg::KIND_DELETE, 16'h0000, 5'd0, 16'h0000,
                       btpt_pkg::ST_OK, 1'b0, 16'h0));
    dir.push_back(row(btpt_pkg::KIND_LOOKUP, 16'h1234, 5'd0, 16'h0000));
    dir.push_back(row(btpt_pkg::KIND_INSERT, 16'h5555, 5'd8, 16'h5A5A));
    dir.push_back(row(btpt_pkg::KIND_DELETE, 16'h5555, 5'd4, 16'h0000));
    dir.push_back(row(btpt_pkg::KIND_LOOKUP, 16'h5555, 5'd16, 16'h0000));
    dir.push_back(trow(KIND_NONE, 16'hFFFF, 5'd31, 16'hFFFF, btpt_pkg::ST_OK, 1'b0, 16'h0));
    foreach (dir[i]) send_req(dir[i]);
    drain();

    // fill the node store with 110 random inserts, then delete the last 40 of them
    for (int i = 0; i < 110; i++) begin
      r = row(btpt_pkg::KIND_INSERT, 16'($urandom), 5'd16, 16'($urandom));
      dir[i % dir.size()] = r;
      pfx_key[i % 40] = r.key;
      send_req(r);
      if (i % 3 == 0) begin
        send_req(row(btpt_pkg::KIND_LOOKUP, 16'($urandom), 5'($urandom), 16'($urandom)));
      end
    end
    for (int i = 0; i < 40; i++) send_req(row(btpt_pkg::KIND_DELETE, pfx_key[i], 5'd16, 16'h0));
    drain();

    for (int i = 0; i < 40; i++) begin
      pfx_key[i] = 16'($urandom);
      pfx_len[i] = ($urandom_range(3) == 0) ? 5'($urandom_range(16)) : 5'($urandom_range(6));
    end
    for (int i = 0; i < 1700; i++) begin
      sel = $urandom_range(39);
      kc = $urandom_range(99);
      r = row(btpt_pkg::KIND_LOOKUP, pfx_key[sel] ^ 16'($urandom_range(255)), pfx_len[sel],
              16'($urandom));
      if (kc < 40) r.kind = btpt_pkg::KIND_INSERT;
      else if (kc < 68) r.kind = btpt_pkg::KIND_DELETE;
      else if (kc < 70) r.kind = KIND_NONE;
      if (r.kind != btpt_pkg::KIND_LOOKUP) r.key = pfx_key[sel];
      if ($urandom_range(19) == 0) r.plen = 5'($urandom);
      if ($urandom_range(9) == 0) r.key = 16'($urandom);
      send_req(r);
      if (i == 900) drain();
    end
    drain();
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("** binary_trie_prefix_table_unit: PASSED **");
    end else begin
      $display("** binary_trie_prefix_table_unit: FAILED **");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/btpt_pkg.sv
rtl/btpt_ctrl.sv
rtl/btpt_dp.sv
rtl/binary_trie_prefix_table_unit.sv
rtl/btpt_checker.sv
tb/sv/testbench.sv
